>>> src/swn_pkg.sv
// ----------------------------------------------------------------------------
// swn_pkg
// shared types, byte codes and whitespace helpers for the normalizer
// ----------------------------------------------------------------------------
package swn_pkg;

    // whitespace code stored in the pending store
    typedef logic [2:0] t_ws_code;

    // decoded whitespace lookup result
    typedef struct packed {
        logic     hit;
        t_ws_code code;
    } t_ws_hit;

    localparam t_ws_code WS_SPACE = 3'd0;
    localparam t_ws_code WS_TAB   = 3'd1;
    localparam t_ws_code WS_VT    = 3'd2;
    localparam t_ws_code WS_FF    = 3'd3;
    localparam t_ws_code WS_CR    = 3'd4;

    localparam logic [7:0] BYTE_NL    = 8'h0A;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_VT    = 8'h0B;
    localparam logic [7:0] BYTE_FF    = 8'h0C;
    localparam logic [7:0] BYTE_CR    = 8'h0D;

    // most result bytes one item can cause
    localparam int MAX_RESULTS = 62;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_STRIP_TRAILING_WS     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPAND_LEADING_TABS   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_BLANK_LINES     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_FINAL_EMPTY_LINE = 4'd3;

    function automatic t_ws_hit ws_code(input logic [7:0] b);
        t_ws_hit r;
        r.hit  = 1'b1;
        r.code = WS_SPACE;
        case (b)
            BYTE_SPACE: r.code = WS_SPACE;
            BYTE_TAB:   r.code = WS_TAB;
            BYTE_VT:    r.code = WS_VT;
            BYTE_FF:    r.code = WS_FF;
            BYTE_CR:    r.code = WS_CR;
            default:    r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ws_byte(input t_ws_code c);
        logic [7:0] b;
        case (c)
            WS_SPACE: b = BYTE_SPACE;
            WS_TAB:   b = BYTE_TAB;
            WS_VT:    b = BYTE_VT;
            WS_FF:    b = BYTE_FF;
            WS_CR:    b = BYTE_CR;
            default:  b = BYTE_SPACE;
        endcase
        return b;
    endfunction

endpackage

>>> src/swn_in_if.sv
// ----------------------------------------------------------------------------
// swn_in_if
// input channel: one text byte with its end-of-file flag
// ----------------------------------------------------------------------------
interface swn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_in_file;

    modport source (output valid, output in_byte, output last_in_file, input ready);
    modport sink   (input valid, input in_byte, input last_in_file, output ready);
endinterface

>>> src/swn_out_if.sv
// ----------------------------------------------------------------------------
// swn_out_if
// output channel: one cleaned byte with run end and overflow flags
// ----------------------------------------------------------------------------
interface swn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;
    logic       ws_overflow;

    modport source (output valid, output out_byte, output run_end, output ws_overflow,
                    input ready);
    modport sink   (input valid, input out_byte, input run_end, input ws_overflow,
                    output ready);
endinterface

>>> src/swn_cfg_if.sv
// ----------------------------------------------------------------------------
// swn_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface swn_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [swn_pkg::CFG_IDX_W-1:0]      index;
    logic [swn_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/source_text_whitespace_normalizer_unit.sv
// ----------------------------------------------------------------------------
// source_text_whitespace_normalizer_unit
// cleans a text byte stream: trailing whitespace, leading tabs, blank lines
// ----------------------------------------------------------------------------
// Takes one text byte per item and sends out the cleaned bytes it causes, one
// byte per cycle while the output side is ready, with run_end set on the last
// byte of that item. An item never sends more than 62 bytes. The single emit
// sequencer walks the pending whitespace store, the direct byte and the newline
// one output byte at a time through the output register. i_in.ready is low
// while an item is being emitted. Whitespace held back for trailing-space
// removal sits in a small register store of PENDING_DEPTH entries; when it is
// full the oldest entry is sent out with ws_overflow set. Configuration writes
// are accepted every cycle and are meant to be issued only while the block is
// idle.
module source_text_whitespace_normalizer_unit #(
    parameter int PENDING_DEPTH = 15
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    swn_cfg_if.sink         i_cfg,
    swn_in_if.sink          i_in,
    swn_out_if.source       o_out
);

    localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);
    localparam int IDX_W  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int OCNT_W = $clog2(swn_pkg::MAX_RESULTS);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FLUSH = 2'd1;
    localparam logic [1:0] S_MAIN  = 2'd2;
    localparam logic [1:0] S_NL    = 2'd3;

    // configuration registers
    logic r_strip, r_expand, r_limit, r_drop;

    // per-file line state
    logic [CNT_W-1:0] r_count,  n_count;
    logic             r_lead,   n_lead;
    logic             r_lhc,    n_lhc;
    logic [1:0]       r_blank,  n_blank;

    // pending whitespace store, oldest entry at index zero
    swn_pkg::t_ws_code r_pend [PENDING_DEPTH];
    swn_pkg::t_ws_code n_pend [PENDING_DEPTH];

    // emit plan latched at accept
    logic [1:0]        r_state,     n_state;
    logic [CNT_W-1:0]  r_fl_cnt,    n_fl_cnt;
    logic [CNT_W-1:0]  r_idx,       n_idx;
    logic [1:0]        r_sub,       n_sub;
    logic [OCNT_W-1:0] r_ocnt,      n_ocnt;
    logic              r_exp_lead,  n_exp_lead;
    logic              r_has_main,  n_has_main;
    logic              r_has_nl,    n_has_nl;
    logic [7:0]        r_main_byte, n_main_byte;
    logic              r_main_four, n_main_four;
    logic              r_main_ov,   n_main_ov;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_end;
    logic       r_out_ov;

    logic       in_ready;
    logic       acc;
    logic       out_free;
    logic       emit_go;
    logic [7:0] e_byte;
    logic       e_end;
    logic       e_ov;

    swn_pkg::t_ws_hit  in_ws;
    swn_pkg::t_ws_code fl_code;
    logic              fl_four;

    assign in_ready    = (r_state == S_IDLE);
    assign i_in.ready  = in_ready;
    assign acc         = i_in.valid && in_ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign emit_go     = (r_state != S_IDLE) && out_free;
    assign i_cfg.ready = 1'b1;

    assign in_ws   = swn_pkg::ws_code(i_in.in_byte);
    assign fl_code = r_pend[r_idx[IDX_W-1:0]];
    assign fl_four = (fl_code == swn_pkg::WS_TAB) && r_exp_lead;

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.run_end     = r_out_end;
    assign o_out.ws_overflow = r_out_ov;

    // accept: decide the whole emit plan and update line state at once
    always_comb begin
        logic is_nl, eof, wstore, ovf, direct, lhc_after, line_end, show;
        logic [1:0] br_inc;
        swn_pkg::t_ws_code oldest;

        n_count     = r_count;
        n_lead      = r_lead;
        n_lhc       = r_lhc;
        n_blank     = r_blank;
        n_pend      = r_pend;
        n_fl_cnt    = r_fl_cnt;
        n_exp_lead  = r_exp_lead;
        n_has_main  = r_has_main;
        n_has_nl    = r_has_nl;
        n_main_byte = r_main_byte;
        n_main_four = r_main_four;
        n_main_ov   = r_main_ov;

        is_nl     = (i_in.in_byte == swn_pkg::BYTE_NL);
        eof       = i_in.last_in_file;
        wstore    = !is_nl && in_ws.hit && r_strip;
        ovf       = wstore && (r_count == CNT_W'(PENDING_DEPTH));
        direct    = !is_nl && !wstore;
        oldest    = r_pend[0];
        lhc_after = r_lhc || direct || ovf;
        line_end  = is_nl || eof;
        br_inc    = (r_blank == 2'd3) ? r_blank : r_blank + 2'd1;
        show      = 1'b0;

        if (acc) begin
            n_exp_lead = r_expand && r_lead;
            n_fl_cnt   = direct ? r_count : '0;
            n_has_main = direct || ovf;
            n_main_ov  = ovf;
            if (ovf) begin
                n_main_byte = swn_pkg::ws_byte(oldest);
                n_main_four = (oldest == swn_pkg::WS_TAB) && r_expand && r_lead;
            end else begin
                n_main_byte = i_in.in_byte;
                n_main_four = in_ws.hit && (in_ws.code == swn_pkg::WS_TAB)
                              && r_expand && r_lead;
            end

            // pending store update
            if (ovf) begin
                for (int i = 0; i < PENDING_DEPTH - 1; i++) begin
                    n_pend[i] = r_pend[i+1];
                end
                n_pend[PENDING_DEPTH-1] = in_ws.code;
                n_count = CNT_W'(PENDING_DEPTH);
            end else if (wstore) begin
                n_pend[r_count[IDX_W-1:0]] = in_ws.code;
                n_count = r_count + CNT_W'(1);
            end else begin
                n_count = '0;
            end

            // content byte leaves the leading region
            n_lead = (direct && !in_ws.hit) ? 1'b0 : r_lead;
            n_lhc  = lhc_after;

            if (line_end) begin
                if (!lhc_after) begin
                    if (!(eof && r_drop)) begin
                        show = 1'b1;
                        if (r_limit) begin
                            n_blank = br_inc;
                            show    = (br_inc != 2'd3);
                        end
                    end
                end else begin
                    show = 1'b1;
                    if (r_limit) begin
                        n_blank = 2'd0;
                    end
                end
                n_count = '0;
                n_lead  = 1'b1;
                n_lhc   = 1'b0;
            end
            if (eof) begin
                n_blank = 2'd0;
            end
            n_has_nl = line_end && show;
        end
    end

    // emit sequencer: one output byte per step
    always_comb begin
        logic last_entry, sub_last, cap;

        n_state    = r_state;
        n_idx      = r_idx;
        n_sub      = r_sub;
        n_ocnt     = r_ocnt;
        e_byte     = swn_pkg::BYTE_NL;
        e_end      = 1'b0;
        e_ov       = 1'b0;
        last_entry = ((r_idx + CNT_W'(1)) == r_fl_cnt);
        sub_last   = 1'b1;
        // an item never sends more than the result limit
        cap        = (r_ocnt == OCNT_W'(swn_pkg::MAX_RESULTS - 1));

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_idx  = '0;
                    n_sub  = 2'd0;
                    n_ocnt = '0;
                    if (n_fl_cnt != '0) begin
                        n_state = S_FLUSH;
                    end else if (n_has_main) begin
                        n_state = S_MAIN;
                    end else if (n_has_nl) begin
                        n_state = S_NL;
                    end
                end
            end
            S_FLUSH: begin
                // expanded tab goes out as four spaces
                sub_last = fl_four ? (r_sub == 2'd3) : 1'b1;
                e_byte   = fl_four ? swn_pkg::BYTE_SPACE : swn_pkg::ws_byte(fl_code);
                e_end    = sub_last && last_entry && !r_has_main && !r_has_nl;
                if (emit_go) begin
                    if (!sub_last) begin
                        n_sub = r_sub + 2'd1;
                    end else begin
                        n_sub = 2'd0;
                        if (last_entry) begin
                            if (r_has_main) begin
                                n_state = S_MAIN;
                            end else if (r_has_nl) begin
                                n_state = S_NL;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_idx = r_idx + CNT_W'(1);
                        end
                    end
                end
            end
            S_MAIN: begin
                sub_last = r_main_four ? (r_sub == 2'd3) : 1'b1;
                e_byte   = r_main_four ? swn_pkg::BYTE_SPACE : r_main_byte;
                e_ov     = r_main_ov;
                e_end    = sub_last && !r_has_nl;
                if (emit_go) begin
                    if (!sub_last) begin
                        n_sub = r_sub + 2'd1;
                    end else begin
                        n_sub   = 2'd0;
                        n_state = r_has_nl ? S_NL : S_IDLE;
                    end
                end
            end
            S_NL: begin
                e_byte = swn_pkg::BYTE_NL;
                e_end  = 1'b1;
                if (emit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // count sent bytes, the last allowed one ends the item
        if (r_state != S_IDLE) begin
            e_end = e_end || cap;
            if (emit_go) begin
                n_ocnt = r_ocnt + OCNT_W'(1);
                if (cap) begin
                    n_state = S_IDLE;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip     <= 1'b0;
            r_expand    <= 1'b0;
            r_limit     <= 1'b0;
            r_drop      <= 1'b0;
            r_count     <= '0;
            r_lead      <= 1'b1;
            r_lhc       <= 1'b0;
            r_blank     <= 2'd0;
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    swn_pkg::REG_STRIP_TRAILING_WS:     r_strip  <= i_cfg.data[0];
                    swn_pkg::REG_EXPAND_LEADING_TABS:   r_expand <= i_cfg.data[0];
                    swn_pkg::REG_LIMIT_BLANK_LINES:     r_limit  <= i_cfg.data[0];
                    swn_pkg::REG_DROP_FINAL_EMPTY_LINE: r_drop   <= i_cfg.data[0];
                    default: ;
                endcase
            end
            r_count <= n_count;
            r_lead  <= n_lead;
            r_lhc   <= n_lhc;
            r_blank <= n_blank;
            r_state <= n_state;
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend      <= n_pend;
        r_fl_cnt    <= n_fl_cnt;
        r_idx       <= n_idx;
        r_sub       <= n_sub;
        r_ocnt      <= n_ocnt;
        r_exp_lead  <= n_exp_lead;
        r_has_main  <= n_has_main;
        r_has_nl    <= n_has_nl;
        r_main_byte <= n_main_byte;
        r_main_four <= n_main_four;
        r_main_ov   <= n_main_ov;
        if (emit_go) begin
            r_out_byte <= e_byte;
            r_out_end  <= e_end;
            r_out_ov   <= e_ov;
        end
    end

endmodule

>>> test/source_text_whitespace_normalizer_unit_tb.sv
// ----------------------------------------------------------------------------
// source_text_whitespace_normalizer_unit_tb
// self-checking regression for the whitespace normalizer
// ----------------------------------------------------------------------------
// A queue of text items feeds a clocked driver. Each accepted item runs through
// a local model of the cleaning rules: held-back trailing whitespace, leading
// tab expansion, blank-line limiting and dropping an empty last line. The model
// appends the cleaned bytes it predicts to a queue. A clocked monitor compares
// every byte the block sends out, field by field, with the oldest prediction.
// The run has a short directed sequence of two files first. Then come several register
// settings, all-clear and all-set among them, each with random source-like
// lines. Sender gaps and receiver stalls vary from phase to phase.
module source_text_whitespace_normalizer_unit_tb;

    localparam int PEND_DEPTH    = 15;
    localparam int MAX_RESULTS   = 62;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 45;
    localparam int RANDOM_PHASES = 6;

    localparam logic [swn_pkg::CFG_IDX_W-1:0] REG_LIST [4] = '{
        swn_pkg::REG_STRIP_TRAILING_WS, swn_pkg::REG_EXPAND_LEADING_TABS,
        swn_pkg::REG_LIMIT_BLANK_LINES, swn_pkg::REG_DROP_FINAL_EMPTY_LINE
    };
    localparam int UNUSED_REG_LO = int'(swn_pkg::REG_DROP_FINAL_EMPTY_LINE) + 1;
    localparam int UNUSED_REG_HI = (1 << swn_pkg::CFG_IDX_W) - 1;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       ws_overflow;
    } t_clean;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in_file;
    } t_text;

    logic i_clk;
    logic i_rst_n;

    swn_cfg_if cfg_if ();
    swn_in_if  in_if ();
    swn_out_if out_if ();

    source_text_whitespace_normalizer_unit #(
        .PENDING_DEPTH(PEND_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // register shadows and per-file model state
    logic       strip_ws;
    logic       expand_tabs;
    logic       limit_blank;
    logic       drop_final;
    logic [7:0] held_ws [PEND_DEPTH];
    int         held_cnt;
    logic       at_line_start;
    logic       line_emitted;
    int         empty_run;

    t_clean step_out [$];
    t_clean expected_clean [$];
    t_text  text_q [$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int          queued_items;
    int          items_sent;
    int          bytes_checked;
    int          ovf_bytes;
    int          cfg_writes;
    int          settings_run;
    int          bad_count;
    int          quiet_cycles;

    // clock: 8 time units
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // cleaning model
    // ------------------------------------------------------------------
    function automatic logic is_blank(input logic [7:0] b);
        return b == swn_pkg::BYTE_SPACE || b == swn_pkg::BYTE_TAB ||
               b == swn_pkg::BYTE_VT || b == swn_pkg::BYTE_FF ||
               b == swn_pkg::BYTE_CR;
    endfunction

    // one step never produces more than MAX_RESULTS bytes
    function automatic void put_clean(input logic [7:0] b, input logic ovf);
        t_clean c;
        c.out_byte    = b;
        c.run_end     = 1'b0;
        c.ws_overflow = ovf;
        if (step_out.size() < MAX_RESULTS) step_out.push_back(c);
    endfunction

    // a tab still in the indent widens to four spaces when enabled
    function automatic void put_blank(input logic [7:0] b, input logic ovf);
        if (b == swn_pkg::BYTE_TAB && expand_tabs && at_line_start) begin
            repeat (4) put_clean(swn_pkg::BYTE_SPACE, ovf);
        end else begin
            put_clean(b, ovf);
        end
        line_emitted = 1'b1;
    endfunction

    function automatic void release_held();
        for (int i = 0; i < held_cnt; i++) put_blank(held_ws[i], 1'b0);
        held_cnt = 0;
    endfunction

    function automatic void take_text_byte(input logic [7:0] b);
        if (is_blank(b)) begin
            if (strip_ws) begin
                // store full: the oldest blank goes out flagged
                if (held_cnt >= PEND_DEPTH) begin
                    put_blank(held_ws[0], 1'b1);
                    for (int i = 1; i < PEND_DEPTH; i++) held_ws[i-1] = held_ws[i];
                    held_cnt = PEND_DEPTH - 1;
                end
                held_ws[held_cnt] = b;
                held_cnt++;
            end else begin
                release_held();
                put_blank(b, 1'b0);
            end
        end else begin
            release_held();
            at_line_start = 1'b0;
            put_clean(b, 1'b0);
            line_emitted = 1'b1;
        end
    endfunction

    function automatic void close_line(input logic last_line);
        logic show;
        held_cnt = 0;
        if (!line_emitted) begin
            if (!(last_line && drop_final)) begin
                show = 1'b1;
                if (limit_blank) begin
                    if (empty_run < 3) empty_run++;
                    if (empty_run > 2) show = 1'b0;
                end
                if (show) put_clean(swn_pkg::BYTE_NL, 1'b0);
            end
        end else begin
            if (limit_blank) empty_run = 0;
            put_clean(swn_pkg::BYTE_NL, 1'b0);
        end
        at_line_start = 1'b1;
        line_emitted  = 1'b0;
    endfunction

    function automatic void clear_file_state();
        held_cnt      = 0;
        at_line_start = 1'b1;
        line_emitted  = 1'b0;
        empty_run     = 0;
    endfunction

    // predicts the cleaned bytes one accepted item causes
    function automatic void normalize_byte(input logic [7:0] b, input logic eof);
        t_clean tail;
        step_out.delete();
        if (b != swn_pkg::BYTE_NL) take_text_byte(b);
        if (b == swn_pkg::BYTE_NL || eof) close_line(eof);
        if (eof) clear_file_state();
        if (step_out.size() != 0) begin
            tail = step_out.pop_back();
            tail.run_end = 1'b1;
            step_out.push_back(tail);
        end
        foreach (step_out[i]) expected_clean.push_back(step_out[i]);
    endfunction

    // ------------------------------------------------------------------
    // driver: text items from the queue, random sender gaps
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_text
        t_text nxt;
        if (!i_rst_n) begin
            in_if.valid        <= 1'b0;
            in_if.in_byte      <= '0;
            in_if.last_in_file <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid) begin
                normalize_byte(in_if.in_byte, in_if.last_in_file);
                items_sent++;
            end
            if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = text_q.pop_front();
                in_if.valid        <= 1'b1;
                in_if.in_byte      <= nxt.in_byte;
                in_if.last_in_file <= nxt.last_in_file;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random receiver stalls, compare against the oldest prediction
    // ------------------------------------------------------------------
    function automatic void log_mismatch(input string why, input t_clean want,
                                         input t_clean got);
        bad_count++;
        if (bad_count <= 10)
            $display("mismatch (%s): want %02h/%0b/%0b got %02h/%0b/%0b",
                     why, want.out_byte, want.run_end, want.ws_overflow,
                     got.out_byte, got.run_end, got.ws_overflow);
    endfunction

    always @(posedge i_clk) begin : check_clean
        t_clean got;
        t_clean want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            if (out_if.valid && out_if.ready) begin
                got.out_byte    = out_if.out_byte;
                got.run_end     = out_if.run_end;
                got.ws_overflow = out_if.ws_overflow;
                bytes_checked++;
                if (expected_clean.size() == 0) begin
                    log_mismatch("no byte expected", '0, got);
                end else begin
                    want = expected_clean.pop_front();
                    if (want.ws_overflow) ovf_bytes++;
                    if (got.out_byte !== want.out_byte || got.run_end !== want.run_end ||
                        got.ws_overflow !== want.ws_overflow)
                        log_mismatch("field differs", want, got);
                end
            end
        end
    end

    // watchdog: ends a run in which nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("source_text_whitespace_normalizer_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_text(input logic [7:0] b, input logic eof);
        t_text t;
        t.in_byte      = b;
        t.last_in_file = eof;
        text_q.push_back(t);
        queued_items++;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(4))
            0:       return swn_pkg::BYTE_SPACE;
            1:       return swn_pkg::BYTE_TAB;
            2:       return swn_pkg::BYTE_VT;
            3:       return swn_pkg::BYTE_FF;
            default: return swn_pkg::BYTE_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_indent();
        return ($urandom_range(1) != 0) ? swn_pkg::BYTE_TAB : swn_pkg::BYTE_SPACE;
    endfunction

    // printable non-blank characters
    function automatic void add_word();
        repeat ($urandom_range(1, 5)) add_text(8'($urandom_range(33, 126)), 1'b0);
    endfunction

    function automatic void gen_line(input bit ends_file);
        int    first;
        int    words;
        t_text tail;
        first = text_q.size();
        case ($urandom_range(9))
            // whitespace-only line
            0: begin
                repeat ($urandom_range(3)) add_text(pick_blank(), 1'b0);
                add_text(swn_pkg::BYTE_NL, 1'b0);
            end
            // run of bare empty lines for the blank-line limit
            1: repeat ($urandom_range(2, 4)) add_text(swn_pkg::BYTE_NL, 1'b0);
            // noise over the whole byte range
            2: begin
                repeat ($urandom_range(1, 6)) add_text(8'($urandom_range(255)), 1'b0);
                add_text(swn_pkg::BYTE_NL, 1'b0);
            end
            // long indent and long trailing run to fill the held store
            3: begin
                repeat ($urandom_range(13, 19)) add_text(pick_indent(), 1'b0);
                add_word();
                repeat ($urandom_range(12, 18)) add_text(pick_blank(), 1'b0);
                add_text(swn_pkg::BYTE_NL, 1'b0);
            end
            default: begin
                repeat ($urandom_range(4)) add_text(pick_indent(), 1'b0);
                words = $urandom_range(1, 3);
                for (int w = 0; w < words; w++) begin
                    if (w != 0) add_text(pick_indent(), 1'b0);
                    add_word();
                end
                repeat ($urandom_range(3)) add_text(pick_blank(), 1'b0);
                add_text(swn_pkg::BYTE_NL, 1'b0);
            end
        endcase
        if (ends_file) begin
            tail = text_q.pop_back();
            // sometimes the file stops without its final newline
            if (text_q.size() > first && $urandom_range(2) == 0) tail = text_q.pop_back();
            tail.last_in_file = 1'b1;
            text_q.push_back(tail);
        end
    endfunction

    task automatic write_reg(input logic [swn_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swn_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        case (idx)
            swn_pkg::REG_STRIP_TRAILING_WS:     strip_ws    = val[0];
            swn_pkg::REG_EXPAND_LEADING_TABS:   expand_tabs = val[0];
            swn_pkg::REG_LIMIT_BLANK_LINES:     limit_blank = val[0];
            swn_pkg::REG_DROP_FINAL_EMPTY_LINE: drop_final  = val[0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // all four registers in a rotated order, junk in the upper data bits,
    // plus one write to an unmapped index
    task automatic set_config(input logic [3:0] bits);
        int                             rot;
        int                             k;
        logic [swn_pkg::CFG_DATA_W-1:0] d;
        rot = $urandom_range(3);
        for (int n = 0; n < 4; n++) begin
            k    = (rot + n) % 4;
            d    = swn_pkg::CFG_DATA_W'($urandom);
            d[0] = bits[k];
            write_reg(REG_LIST[k], d);
        end
        write_reg(swn_pkg::CFG_IDX_W'($urandom_range(UNUSED_REG_LO, UNUSED_REG_HI)),
                  swn_pkg::CFG_DATA_W'($urandom));
        settings_run++;
    endtask

    task automatic set_idle(input t_idle mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 67; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            IDLE_BOTH:     begin send_idle_pct = 11; recv_stall_pct = 11; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // wait until the block has taken and answered everything, then let a
    // zero-result item finish
    task automatic drain();
        while (text_q.size() != 0 || in_if.valid || expected_clean.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [3:0] cfg_bits, input t_idle mode);
        int goal;
        set_config(cfg_bits);
        set_idle(mode);
        goal = queued_items + PHASE_ITEMS;
        while (queued_items < goal) gen_line($urandom_range(5) == 0);
        // sometimes leave a line open so the next setting starts mid-line
        if ($urandom_range(1) != 0) begin
            repeat ($urandom_range(3)) add_text(pick_indent(), 1'b0);
            add_word();
            repeat ($urandom_range(1, 4)) add_text(pick_blank(), 1'b0);
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        strip_ws    = 1'b0;
        expand_tabs = 1'b0;
        limit_blank = 1'b0;
        drop_final  = 1'b0;
        clear_file_state();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queued_items   = 0;
        cfg_writes     = 0;
        settings_run   = 0;

        i_rst_n      = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed file with every rule enabled
        set_config(4'b1111);
        set_idle(IDLE_NONE);
        // sixteen blanks: the indent overflows the held store
        for (int r = 0; r < 3; r++) begin
            add_text(swn_pkg::BYTE_SPACE, 1'b0);
            add_text(swn_pkg::BYTE_TAB, 1'b0);
            add_text(swn_pkg::BYTE_VT, 1'b0);
            add_text(swn_pkg::BYTE_FF, 1'b0);
            add_text(swn_pkg::BYTE_CR, 1'b0);
        end
        add_text(swn_pkg::BYTE_SPACE, 1'b0);
        // nul counts as content and commits the held indent
        add_text(8'h00, 1'b0);
        // trailing space and carriage return get stripped
        add_text(swn_pkg::BYTE_SPACE, 1'b0);
        add_text(swn_pkg::BYTE_CR, 1'b0);
        add_text(swn_pkg::BYTE_NL, 1'b0);
        // three empty lines, the third is suppressed
        repeat (3) add_text(swn_pkg::BYTE_NL, 1'b0);
        // last byte of the file is content, newline gets appended
        add_text(8'hFF, 1'b1);
        // file made of one empty line, dropped
        add_text(swn_pkg::BYTE_NL, 1'b1);
        drain();

        run_phase(4'b0000, IDLE_NONE);
        run_phase(4'b1111, IDLE_SENDER);
        for (int p = 2; p < RANDOM_PHASES; p++) run_phase(4'($urandom), t_idle'(p % 4));

        $display("covered %0d text items under %0d register settings (%0d config writes)",
                 items_sent, settings_run, cfg_writes);
        $display("checked %0d cleaned bytes, %0d from store overflow, %0d mismatches",
                 bytes_checked, ovf_bytes, bad_count);
        if (bad_count == 0 && expected_clean.size() == 0) begin
            $display("source_text_whitespace_normalizer_unit regression: pass");
        end else begin
            $display("source_text_whitespace_normalizer_unit regression: fail");
        end
        $finish;
    end

endmodule
